@@ design/mt_pkg.sv @@
package mt_pkg;

  // Store geometry
  localparam int unsigned N     = 624;
  localparam int unsigned M     = 397;
  localparam int unsigned IDX_W = 10;

  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(N - 1);
  localparam logic [IDX_W-1:0] IDX_FAR_HI = IDX_W'(N - M);
  localparam logic [IDX_W-1:0] IDX_OFF_M  = IDX_W'(M);

  // Generator constants
  localparam logic [31:0] MATRIX_A  = 32'h9908_b0df;
  localparam logic [31:0] UPPER_MSK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MSK = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;
  localparam logic [31:0] INIT_MULT = 32'd1812433253;

  // Request operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_WR,
    ST_SEED_ADD,
    ST_READ,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic seed_load;
    logic seed_wr;
    logic seed_add;
    logic rd_issue;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic seed_last;
  } status_t;

  // Standard output tempering
  function automatic logic [31:0] mt_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ design/mt_ctrl.sv @@
module mt_ctrl import mt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_operation,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_commit;
  logic   accept;

  // Commit only when the output register is free or being emptied
  assign can_commit = (state_r == ST_COMMIT) && (!out_valid_r || !out_stall);
  assign in_stall   = !((state_r == ST_IDLE) || can_commit);
  assign accept     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == OP_NEXT) ? ST_READ : ST_SEED_WR;
        end
      end
      ST_SEED_WR:  state_nxt = status.seed_last ? ST_IDLE : ST_SEED_ADD;
      ST_SEED_ADD: state_nxt = ST_SEED_WR;
      ST_READ:     state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (can_commit) begin
          if (accept) begin
            state_nxt = (in_operation == OP_NEXT) ? ST_READ : ST_SEED_WR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.seed_load = accept && (in_operation == OP_SEED);
    cmd.seed_wr   = (state_r == ST_SEED_WR);
    cmd.seed_add  = (state_r == ST_SEED_ADD);
    cmd.rd_issue  = (state_r == ST_READ);
    cmd.commit    = can_commit;
  end

  // Output valid: set on commit, drop once the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/mt_dpath.sv @@
module mt_dpath import mt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [31:0] seed_value,
  output status_t     status,
  output logic [31:0] random_word
);

  logic [31:0]      mem [N];
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] pos_inc;
  logic [IDX_W-1:0] far_idx;
  logic [31:0]      prev_r;
  logic [31:0]      prod_r;
  logic [31:0]      cur_r;
  logic [31:0]      rd_nxt_r;
  logic [31:0]      rd_far_r;
  logic [31:0]      out_r;
  logic [31:0]      mix;
  logic [31:0]      twist_w;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  assign status.seed_last = (idx_r == IDX_LAST);
  assign random_word      = out_r;
  assign idx_inc          = idx_r + 1'b1;

  // Neighbor and far indices, wrapped at the store depth
  assign pos_inc = (pos_r == IDX_LAST) ? '0 : pos_r + 1'b1;
  assign far_idx = (pos_r >= IDX_FAR_HI) ? pos_r - IDX_FAR_HI : pos_r + IDX_OFF_M;

  // Twist: upper bit of the current word, lower bits of the next one
  assign mix     = (cur_r & UPPER_MSK) | (rd_nxt_r & LOWER_MSK);
  assign twist_w = rd_far_r ^ (mix >> 1) ^ (mix[0] ? MATRIX_A : 32'd0);

  // Single write port: seed fill or twist commit
  always_comb begin
    wr_en   = cmd.seed_wr || cmd.commit;
    wr_addr = cmd.seed_wr ? idx_r : pos_r;
    wr_data = cmd.seed_wr ? prev_r : twist_w;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rd_nxt_r <= mem[pos_inc];
      rd_far_r <= mem[far_idx];
    end
  end

  // Seed fill: multiply in the write state, add the index in the add state after it
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      prev_r <= seed_value;
      idx_r  <= '0;
    end else if (cmd.seed_add) begin
      prev_r <= prod_r + {{(32 - IDX_W){1'b0}}, idx_inc};
      idx_r  <= idx_inc;
    end
    if (cmd.seed_wr) begin
      prod_r <= INIT_MULT * (prev_r ^ (prev_r >> 30));
    end
  end

  // Cache of the word at the current position
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      cur_r <= seed_value;
    end else if (cmd.commit) begin
      cur_r <= rd_nxt_r;
    end
    if (cmd.commit) begin
      out_r <= mt_temper(twist_w);
    end
  end

  // Position: seed restarts it, commit advances it
  always_comb begin
    pos_nxt = pos_r;
    priority if (cmd.seed_load) begin
      pos_nxt = '0;
    end else if (cmd.commit) begin
      pos_nxt = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ design/mt19937_generator.sv @@
// Channel   Direction  Handshake             Payload
// in_       request    in_valid / in_stall   in_operation, in_seed_value
// out_      result     out_valid / out_stall out_random_word
//
// A next request goes through a read state, which reads the next and far
// words from the two read ports of the store, then a commit state that twists,
// tempers, writes back, loads the output register and can take a new request.
// A seed request fills the 624-word store in alternating write and add states
// for the dependent multiply and add; requests are stalled meanwhile.
// A finished result waits in the output register; a twist that finds it full
// holds until out_stall drops. Reset clears control state only.
module mt19937_generator import mt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_word
);

  cmd_t    cmd;
  status_t status;

  // Sequence requests
  mt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Store, twist and temper
  mt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .seed_value  (in_seed_value),
    .status      (status),
    .random_word (out_random_word)
  );

endmodule

@@ design/mt_checker.sv @@
module mt_checker import mt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_random_word
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_random_word))
    else $error("stalled result changed");

  // Stall the cycle after any accepted request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // No new result at the start of a seed fill, beyond one committed with its accept
  a_seed_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_SEED) |=> ##1 !$rose(out_valid))
    else $error("result appeared during seed fill");

  // Drop output valid out of reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind mt19937_generator mt_checker u_mt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_random_word (out_random_word)
);

@@ tb/mt19937_generator_tb.sv @@
module mt19937_generator_tb;
  import mt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 1300;
  localparam int unsigned PHASE_BUDGET  = 240;
  localparam int unsigned MAX_REPORTS   = 100;

  // Predictor of the twister: holds its own store, position and the words still owed
  class mt_scoreboard;
    logic [31:0]      twist_words [N];
    int unsigned      word_pos;
    logic [31:0]      owed_words [$];
    int unsigned      mismatches;
    int unsigned      words_checked;
    int unsigned      seeds_loaded;
    int unsigned      run_len;
    int unsigned      longest_run;

    function new();
      word_pos      = 0;
      mismatches    = 0;
      words_checked = 0;
      seeds_loaded  = 0;
      run_len       = 0;
      longest_run   = 0;
    endfunction

    // Print one line per mismatch up to MAX_REPORTS, count all of them
    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] MISMATCH %s: got %08h expected %08h", $realtime, what, got, want);
    endtask

    // Advance the predictor on an accepted request
    function void note_request(input logic op, input logic [31:0] seed);
      logic [31:0] prev;
      logic [31:0] mix;
      logic [31:0] y;
      int unsigned nxt;
      int unsigned far_idx;
      if (op == OP_SEED) begin
        twist_words[0] = seed;
        for (int unsigned i = 1; i < N; i++) begin
          prev = twist_words[i-1];
          twist_words[i] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(i);
        end
        word_pos = 0;
        seeds_loaded++;
        run_len = 0;
      end else begin
        nxt     = (word_pos == N - 1) ? 0 : word_pos + 1;
        far_idx = word_pos + M;
        if (far_idx >= N) far_idx -= N;
        // Twist the current word in place
        mix = (twist_words[word_pos] & UPPER_MSK) | (twist_words[nxt] & LOWER_MSK);
        y   = twist_words[far_idx] ^ (mix >> 1) ^ (mix[0] ? MATRIX_A : 32'h0);
        twist_words[word_pos] = y;
        // Temper the new word
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        owed_words = {owed_words, y};
        word_pos = nxt;
        run_len++;
        if (run_len > longest_run) longest_run = run_len;
      end
    endfunction

    // Compare an accepted result with the oldest owed word
    task check_word(input logic [31:0] got);
      logic [31:0] want;
      if (owed_words.size() == 0) begin
        report_mismatch("word with none owed", got, 32'h0);
      end else begin
        want = owed_words.pop_front();
        words_checked++;
        if (got !== want) report_mismatch("random_word", got, want);
      end
    endtask
  endclass

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic        in_operation  = OP_SEED;
  logic [31:0] in_seed_value = 32'h0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [31:0] out_random_word;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  request_count = 0;
  mt_scoreboard board = new();

  mt19937_generator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_random_word);
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic op, input logic [31:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_seed_value <= seed;
    do @(posedge clk); while (in_stall);
    board.note_request(op, seed);
    request_count++;
  endtask

  // Seed, then draw a run of words with junk in the ignored seed field
  task automatic seeded_run(input logic [31:0] seed, input int unsigned words);
    send_request(OP_SEED, seed);
    for (int unsigned k = 0; k < words; k++) send_request(OP_NEXT, $urandom());
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned words;
    int unsigned seq_idx;
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    send_pct = '{0, 69, 0, 29};
    recv_pct = '{0, 0, 69, 29};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: seed extremes, back-to-back seeds, extremes of the ignored field
    send_request(OP_SEED, 32'h0000_0000);
    send_request(OP_NEXT, 32'h0000_0000);
    send_request(OP_NEXT, 32'hffff_ffff);
    send_request(OP_NEXT, 32'h0000_0000);
    send_request(OP_SEED, 32'hffff_ffff);
    send_request(OP_NEXT, 32'hffff_ffff);
    send_request(OP_NEXT, 32'h0000_0000);
    send_request(OP_SEED, 32'd5489);
    for (int k = 0; k < 4; k++) send_request(OP_NEXT, 32'hffff_ffff);
    send_request(OP_SEED, 32'h0000_0001);
    send_request(OP_SEED, 32'h8000_0000);
    send_request(OP_NEXT, 32'h5555_5555);
    send_request(OP_NEXT, 32'haaaa_aaaa);
    send_request(OP_SEED, 32'h7fff_ffff);
    send_request(OP_NEXT, 32'h0000_0000);

    // Random: seeded runs; the first and last phases open with a run that wraps the position
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_idle_pct = recv_pct[phase];
      phase_start   = request_count;
      seq_idx       = 0;
      while (request_count - phase_start < PHASE_BUDGET) begin
        if ((phase == 0 || phase == 3) && seq_idx == 0)
          words = $urandom_range(700, 630);
        else if ($urandom_range(7) == 0)
          words = 0;
        else
          words = $urandom_range(60, 1);
        seeded_run($urandom(), words);
        seq_idx++;
      end
    end

    // Drain owed words, then watch for strays
    in_valid <= 1'b0;
    while (board.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.owed_words.size() != 0)
      board.report_mismatch("words left owed", 32'h0, 32'(board.owed_words.size()));

    $display("Covered %0d requests: %0d seeds and %0d words checked over four stall phases",
             request_count, board.seeds_loaded, board.words_checked);
    $display("Longest run from one seed: %0d words, mismatches: %0d",
             board.longest_run, board.mismatches);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mt_pkg.sv
design/mt_ctrl.sv
design/mt_dpath.sv
design/mt19937_generator.sv
design/mt_checker.sv
tb/mt19937_generator_tb.sv
